FILE: rtl/core/rtt_pkg.sv
// ============================================================================
// rtt_pkg
// Shared widths, codes and types for the retransmit timer table.
// ============================================================================
package rtt_pkg;

    localparam int ID_W       = 32;
    localparam int KIND_W     = 4;
    localparam int RETRY_W    = 3;
    localparam int AGE_W      = 8;
    localparam int SLOT_W     = 4;
    localparam int EV_W       = 3;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // input actions
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    // result events
    localparam logic [EV_W-1:0] EV_TRANSMIT = 3'd0;
    localparam logic [EV_W-1:0] EV_RESEND   = 3'd1;
    localparam logic [EV_W-1:0] EV_GIVEUP   = 3'd2;
    localparam logic [EV_W-1:0] EV_ACKED    = 3'd3;
    localparam logic [EV_W-1:0] EV_UNKNOWN  = 3'd4;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 1'd1;

    localparam logic [AGE_W-1:0]   TIMEOUT_RST = 8'd4;
    localparam logic [RETRY_W-1:0] LIMIT_RST   = 3'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [KIND_W-1:0]  kind;
        logic [RETRY_W-1:0] retries;
        logic [AGE_W-1:0]   age;
    } t_entry;

    typedef struct packed {
        logic [EV_W-1:0]    ev;
        logic [ID_W-1:0]    id;
        logic [KIND_W-1:0]  kind;
        logic [RETRY_W-1:0] retries;
        logic [SLOT_W-1:0]  slot;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic read;
        logic eval;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_slot;
        logic eval_done;
        logic fin_done;
    } t_sts;

endpackage

FILE: rtl/core/rtt_ram.sv
// ============================================================================
// rtt_ram
// Generic RAM: one write port, one read port, registered read data.
// ============================================================================
module rtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rtt_ctrl.sv
// ============================================================================
// rtt_ctrl
// Sequencer: accept an item, scan every slot (read, then evaluate), finish.
// ============================================================================
module rtt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output rtt_pkg::t_cmd o_cmd,
    input  rtt_pkg::t_sts i_sts
);
    import rtt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (i_sts.eval_done) begin
                    n_state = i_sts.last_slot ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (i_sts.fin_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_cmd.accept  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.read    = (r_state == S_RD);
    assign o_cmd.eval    = (r_state == S_EV);
    assign o_cmd.finish  = (r_state == S_FIN);

endmodule

FILE: rtl/core/rtt_dpath.sv
// ============================================================================
// rtt_dpath
// Entry storage, valid bits, scan trackers, pending result and output beat.
// ============================================================================
module rtt_dpath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rtt_pkg::t_cmd                     i_cmd,
    output rtt_pkg::t_sts                     o_sts,
    input  logic [rtt_pkg::ACT_W-1:0]         i_action,
    input  logic [rtt_pkg::ID_W-1:0]          i_msg_id,
    input  logic [rtt_pkg::KIND_W-1:0]        i_msg_kind,
    input  logic                              i_cfg_we,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rtt_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_stall,
    output logic                              o_valid,
    output rtt_pkg::t_result                  o_res,
    output logic                              o_last
);
    import rtt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // configuration
    logic [AGE_W-1:0]   r_timeout;
    logic [RETRY_W-1:0] r_limit;

    // current item
    logic [ACT_W-1:0]   r_action;
    logic [ID_W-1:0]    r_id;
    logic [KIND_W-1:0]  r_kind;
    logic [IDX_W-1:0]   r_idx;

    logic [TABLE_DEPTH-1:0] r_valid;

    // scan trackers for send and ack
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_slot;
    logic [KIND_W-1:0]  r_hit_kind;
    logic [RETRY_W-1:0] r_hit_retries;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_slot;

    logic    r_pend_valid;
    t_result r_pend;
    logic    r_out_valid;
    t_result r_out;
    logic    r_out_last;

    logic [$bits(t_entry)-1:0] ram_rdata;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    t_entry                    ram_wdata;

    t_entry           rd;
    logic             slot_valid;
    logic [AGE_W-1:0] age_inc;
    logic             timed_out;
    logic             give_up;
    logic             is_send;
    logic             is_ack;
    logic             is_tick;
    logic             tick_res;
    logic             out_free;
    logic             eval_go;
    logic             fin_has_res;
    logic             fin_go;
    logic [IDX_W-1:0] send_slot;
    logic             send_ok;
    t_result          new_res;
    t_result          fin_res;

    assign rd         = t_entry'(ram_rdata);
    assign slot_valid = r_valid[r_idx];
    assign age_inc    = (rd.age == '1) ? rd.age : rd.age + AGE_W'(1);
    assign timed_out  = (age_inc >= r_timeout);
    assign give_up    = (rd.retries >= r_limit);
    assign is_send    = (r_action == ACT_SEND);
    assign is_ack     = (r_action == ACT_ACK);
    assign is_tick    = (r_action == ACT_TICK);
    assign tick_res   = is_tick && slot_valid && timed_out;
    assign out_free   = !r_out_valid || !i_stall;
    // a second tick result needs the output register to take the pending one
    assign eval_go    = i_cmd.eval && !(tick_res && r_pend_valid && !out_free);

    assign fin_has_res = r_pend_valid || is_send || is_ack;
    assign fin_go      = i_cmd.finish && (!fin_has_res || out_free);
    assign send_slot   = r_hit ? r_hit_slot : r_free_slot;
    assign send_ok     = r_hit || r_free_found;

    always_comb begin
        new_res.ev      = give_up ? EV_GIVEUP : EV_RESEND;
        new_res.id      = rd.id;
        new_res.kind    = rd.kind;
        new_res.retries = give_up ? rd.retries : rd.retries + RETRY_W'(1);
        new_res.slot    = SLOT_W'(r_idx);
    end

    always_comb begin
        fin_res.ev      = EV_UNKNOWN;
        fin_res.id      = r_id;
        fin_res.kind    = '0;
        fin_res.retries = '0;
        fin_res.slot    = '0;
        priority if (r_pend_valid) begin
            fin_res = r_pend;
        end else if (is_send) begin
            fin_res.kind = r_kind;
            if (send_ok) begin
                fin_res.ev   = EV_TRANSMIT;
                fin_res.slot = SLOT_W'(send_slot);
            end else begin
                fin_res.ev = EV_FULL;
            end
        end else if (is_ack && r_hit) begin
            fin_res.ev      = EV_ACKED;
            fin_res.kind    = r_hit_kind;
            fin_res.retries = r_hit_retries;
            fin_res.slot    = SLOT_W'(r_hit_slot);
        end else begin
            // unknown id on ack: report the input id only
            fin_res.ev = EV_UNKNOWN;
        end
    end

    // tick write-back during the scan, new entry at the end of a send
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = rd;
        if (eval_go && is_tick && slot_valid && !(timed_out && give_up)) begin
            ram_we            = 1'b1;
            ram_wdata.retries = timed_out ? rd.retries + RETRY_W'(1) : rd.retries;
            ram_wdata.age     = timed_out ? '0 : age_inc;
        end else if (fin_go && is_send && send_ok) begin
            ram_we            = 1'b1;
            ram_waddr         = send_slot;
            ram_wdata.id      = r_id;
            ram_wdata.kind    = r_kind;
            ram_wdata.retries = '0;
            ram_wdata.age     = '0;
        end
    end

    rtt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.read),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_action <= i_action;
            r_id     <= i_msg_id;
            r_kind   <= i_msg_kind;
            r_idx    <= '0;
        end else if (eval_go && !o_sts.last_slot) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (eval_go && slot_valid && !r_hit && rd.id == r_id) begin
            r_hit_slot    <= r_idx;
            r_hit_kind    <= rd.kind;
            r_hit_retries <= rd.retries;
        end
        if (eval_go && !slot_valid && !r_free_found) begin
            r_free_slot <= r_idx;
        end
        if (eval_go && tick_res) begin
            r_pend <= new_res;
        end
        if (fin_go && fin_has_res) begin
            r_out      <= fin_res;
            r_out_last <= 1'b1;
        end else if (eval_go && tick_res && r_pend_valid) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RST;
            r_limit      <= LIMIT_RST;
            r_valid      <= '0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else if (i_cfg_idx == CFG_LIMIT) begin
                    r_limit <= i_cfg_data[RETRY_W-1:0];
                end
            end

            if (i_cmd.accept) begin
                r_hit        <= 1'b0;
                r_free_found <= 1'b0;
            end else if (eval_go && !is_tick) begin
                if (slot_valid && rd.id == r_id) begin
                    r_hit <= 1'b1;
                end
                if (!slot_valid) begin
                    r_free_found <= 1'b1;
                end
            end

            // drop given-up entries, claim on send, free on ack
            if (eval_go && tick_res && give_up) begin
                r_valid[r_idx] <= 1'b0;
            end else if (fin_go && is_send && send_ok) begin
                r_valid[send_slot] <= 1'b1;
            end else if (fin_go && is_ack && r_hit) begin
                r_valid[r_hit_slot] <= 1'b0;
            end

            if (fin_go) begin
                r_pend_valid <= 1'b0;
            end else if (eval_go && tick_res) begin
                r_pend_valid <= 1'b1;
            end

            if ((fin_go && fin_has_res) || (eval_go && tick_res && r_pend_valid)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last_slot = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign o_sts.eval_done = eval_go;
    assign o_sts.fin_done  = fin_go;

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/core/retransmit_timer_table_top.sv
// ============================================================================
// retransmit_timer_table_top
// Retransmission timer table for messages awaiting acknowledgement.
// ============================================================================
// Input channel (i_valid / o_stall) carries one action per beat: send
// registers an id and kind, ack removes a pending id, tick ages every entry.
// Output channel (o_valid / i_stall) returns result beats; o_last marks the
// final beat of one input. Send and ack give exactly one beat, a tick gives
// one beat per timed-out entry in slot order (possibly none), action 3 none.
// Each item walks all slots of the entry RAM, a read step and then an
// evaluate step per slot, since the entry RAM has a single read port.
// The input is stalled for the whole walk, so a new item is taken only
// once the last one has finished. The final beat of an item is registered
// when its finish step completes.
// A result beat sits in an output register while the next item is accepted.
// When the receiver stalls, the walk pauses only where a second beat of a
// tick has nowhere to go, and the finish step waits for the output register.
// Synchronous reset empties the table (valid bits cleared at once), restores
// timeout_ticks = 4 and retry_limit = 3, and drops any pending beat.
// Configuration writes (i_cfg_we) take effect at the next edge.
// ============================================================================
module retransmit_timer_table_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [rtt_pkg::ACT_W-1:0]          i_action,
    input  logic [rtt_pkg::ID_W-1:0]           i_msg_id,
    input  logic [rtt_pkg::KIND_W-1:0]         i_msg_kind,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [rtt_pkg::EV_W-1:0]           o_event_res,
    output logic [rtt_pkg::ID_W-1:0]           o_out_id,
    output logic [rtt_pkg::KIND_W-1:0]         o_out_kind,
    output logic [rtt_pkg::RETRY_W-1:0]        o_retry_count,
    output logic [rtt_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_last,
    input  logic                               i_cfg_we,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rtt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rtt_pkg::*;

    t_cmd    cmd;
    t_sts    sts;
    t_result res;

    rtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    rtt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_action   (i_action),
        .i_msg_id   (i_msg_id),
        .i_msg_kind (i_msg_kind),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (res),
        .o_last     (o_last)
    );

    assign o_event_res   = res.ev;
    assign o_out_id      = res.id;
    assign o_out_kind    = res.kind;
    assign o_retry_count = res.retries;
    assign o_slot        = res.slot;

endmodule

FILE: rtl/core/rtt_checker.sv
// ============================================================================
// rtt_checker
// Port-level checks on the retransmit timer table, bound to the top level.
// ============================================================================
module rtt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [rtt_pkg::EV_W-1:0]    o_event_res
);
    import rtt_pkg::*;

    // a stalled beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    // an accepted item keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accept");

    // only defined event codes leave the block
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_event_res <= EV_FULL))
        else $error("undefined event code on output");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind retransmit_timer_table_top rtt_checker u_rtt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_event_res (o_event_res)
);
